@@ sv/cpm_pkg.sv @@
// ----------------------------------------------------------------------------
// cpm_pkg: shared types and constants for the complex polynomial pixel map
// Beat layout between cells, coefficient type, register indexes and the
// Q16.16 saturation helper.
// ----------------------------------------------------------------------------
package cpm_pkg;

  localparam int MAX_TERMS_DEF = 10;
  localparam int COEF_SLOTS    = 10;
  localparam int PAIR_REGS     = 5;
  localparam int CFG_IDX_W     = 3;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_COEF_PAIR_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TERM_COUNT  = 3'd5;

  localparam logic signed [31:0] INVALID_MARK32 = -32'sd1000;
  localparam logic signed [15:0] INVALID_MARK16 = -16'sd1000;

  localparam logic signed [49:0] Q_MAX = 50'sd2147483647;
  localparam logic signed [49:0] Q_MIN = -50'sd2147483648;

  typedef struct packed {
    logic signed [15:0] im;
    logic signed [15:0] re;
  } cpm_coef_t;

  typedef struct packed {
    logic signed [31:0] w_re;
    logic signed [31:0] w_im;
    logic signed [31:0] z_re;
    logic signed [31:0] z_im;
    logic signed [15:0] cnt;
    logic               pix_ok;
    logic               sat;
  } cpm_beat_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               clip;
  } cpm_sat_t;

  function automatic cpm_sat_t sat32(input logic signed [49:0] v);
    cpm_sat_t s;
    if (v > Q_MAX) begin
      s.val  = 32'sh7FFF_FFFF;
      s.clip = 1'b1;
    end else if (v < Q_MIN) begin
      s.val  = 32'sh8000_0000;
      s.clip = 1'b1;
    end else begin
      s.val  = v[31:0];
      s.clip = 1'b0;
    end
    return s;
  endfunction

endpackage

@@ sv/cpm_cfg.sv @@
// ----------------------------------------------------------------------------
// cpm_cfg: configuration registers
// Holds the coefficient pair registers and the term count, and hands each
// cell its coefficient, forced to zero above the active term count.
// ----------------------------------------------------------------------------
module cpm_cfg #(
  parameter int MAX_TERMS = cpm_pkg::MAX_TERMS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [cpm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data,
  output cpm_pkg::cpm_coef_t            coef [MAX_TERMS]
);
  import cpm_pkg::*;

  logic [63:0] pair_r    [PAIR_REGS];
  logic [63:0] pair_nxt  [PAIR_REGS];
  logic [3:0]  term_r;
  logic [3:0]  term_nxt;
  logic [4:0]  n_eff;

  always_comb begin
    pair_nxt = pair_r;
    term_nxt = term_r;
    if (cfg_valid) begin
      if (cfg_index == REG_TERM_COUNT) begin
        term_nxt = cfg_data[3:0];
      end else if (cfg_index < REG_TERM_COUNT) begin
        pair_nxt[cfg_index - REG_COEF_PAIR_0] = cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < PAIR_REGS; p++) pair_r[p] <= '0;
      term_r <= 4'd1;
    end else begin
      pair_r <= pair_nxt;
      term_r <= term_nxt;
    end
  end

  // zero terms act as one; clamp to the chain length
  always_comb begin
    n_eff = {1'b0, term_r};
    if (term_r == 4'd0) n_eff = 5'd1;
    if (n_eff > 5'(MAX_TERMS)) n_eff = 5'(MAX_TERMS);
  end

  for (genvar k = 0; k < MAX_TERMS; k++) begin : g_coef
    if (k < COEF_SLOTS) begin : g_stored
      logic [31:0] slot;
      assign slot = (k % 2 == 1) ? pair_r[k/2][63:32] : pair_r[k/2][31:0];
      always_comb begin
        coef[k] = '0;
        if (5'(k) < n_eff) begin
          coef[k].re = slot[15:0];
          coef[k].im = slot[31:16];
        end
      end
    end else begin : g_empty
      assign coef[k] = '0;
    end
  end

endmodule

@@ sv/cpm_cell.sv @@
// ----------------------------------------------------------------------------
// cpm_cell: one Horner step, w = w*z + c
// Stage A forms the four Q32.32 products, stage B rounds to Q16.16, adds
// the coefficient and clips. Each stage stalls only when full and blocked.
// ----------------------------------------------------------------------------
module cpm_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  cpm_pkg::cpm_coef_t coef,
  input  logic               up_valid,
  output logic               up_ready,
  input  cpm_pkg::cpm_beat_t up_beat,
  output logic               dn_valid,
  input  logic               dn_ready,
  output cpm_pkg::cpm_beat_t dn_beat
);
  import cpm_pkg::*;

  logic               a_v_r, a_v_nxt;
  cpm_beat_t          a_beat_r;
  logic signed [63:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic               b_v_r, b_v_nxt;
  cpm_beat_t          b_beat_r, b_beat_nxt;
  logic               a_ready, b_ready;

  logic signed [64:0] sum_re, sum_im;
  logic signed [49:0] c_re, c_im, v_re, v_im;
  cpm_sat_t           s_re, s_im;

  assign b_ready  = !b_v_r || dn_ready;
  assign a_ready  = !a_v_r || b_ready;
  assign up_ready = a_ready;
  assign a_v_nxt  = a_ready ? up_valid : a_v_r;
  assign b_v_nxt  = b_ready ? a_v_r : b_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      a_v_r <= a_v_nxt;
      b_v_r <= b_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && up_valid) begin
      a_beat_r <= up_beat;
      p_rr_r   <= 64'(up_beat.w_re) * 64'(up_beat.z_re);
      p_ii_r   <= 64'(up_beat.w_im) * 64'(up_beat.z_im);
      p_ri_r   <= 64'(up_beat.w_re) * 64'(up_beat.z_im);
      p_ir_r   <= 64'(up_beat.w_im) * 64'(up_beat.z_re);
    end
  end

  // round half up, then add the coefficient scaled from Q4.12
  always_comb begin
    sum_re = 65'(p_rr_r) - 65'(p_ii_r) + 65'sd32768;
    sum_im = 65'(p_ri_r) + 65'(p_ir_r) + 65'sd32768;
    c_re   = {{30{coef.re[15]}}, coef.re, 4'b0000};
    c_im   = {{30{coef.im[15]}}, coef.im, 4'b0000};
    v_re   = {sum_re[64], sum_re[64:16]} + c_re;
    v_im   = {sum_im[64], sum_im[64:16]} + c_im;
    s_re   = sat32(v_re);
    s_im   = sat32(v_im);
    b_beat_nxt      = a_beat_r;
    b_beat_nxt.w_re = s_re.val;
    b_beat_nxt.w_im = s_im.val;
    b_beat_nxt.sat  = a_beat_r.sat | s_re.clip | s_im.clip;
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_v_r) begin
      b_beat_r <= b_beat_nxt;
    end
  end

  assign dn_valid = b_v_r;
  assign dn_beat  = b_beat_r;

`ifndef ASSERT_OFF
  a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
    !a_v_r |-> up_ready)
    else $error("cell refuses a beat with stage A empty");

  b_hold: assert property (@(posedge clk) disable iff (!rst_n)
    b_v_r && !dn_ready |=> b_v_r && $stable(b_beat_r))
    else $error("stalled stage B beat changed or dropped");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    a_v_r && !b_ready |=> a_v_r && $stable(p_rr_r) && $stable(p_ii_r))
    else $error("stalled stage A products changed or dropped");
`endif

endmodule

@@ sv/complex_polynomial_pixel_map.sv @@
// ----------------------------------------------------------------------------
// complex_polynomial_pixel_map: Horner evaluation of a complex polynomial
// Maps a Q16.16 point through a polynomial of up to MAX_TERMS Q4.12
// coefficients, with saturation flag and invalid-pixel marker.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and returns one result per clock while
// out_tready stays high. A row of MAX_TERMS cells each performs one Horner
// step in two registered stages (four 32x32 multiplies, then round, add the
// coefficient and clip), followed by an output register. Unused high-order
// terms run as zero coefficients, so the latency does not depend on
// term_count. Each stage holds its beat only while the stage after it is
// full and blocked, so bubbles are squeezed out under backpressure.
// Configuration writes are always taken and should be made while idle.
module complex_polynomial_pixel_map #(
  parameter int MAX_TERMS = cpm_pkg::MAX_TERMS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cpm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data,
  // input pixels
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [79:0]                   in_tdata,   // point_re, point_im, inversion_count
  // results
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [79:0]                   out_tdata,  // value_re, value_im, count_out
  output logic [1:0]                    out_tuser   // pixel_valid, saturated
);
  import cpm_pkg::*;

  cpm_coef_t coef [MAX_TERMS];
  logic      ch_valid [MAX_TERMS+1];
  logic      ch_ready [MAX_TERMS+1];
  cpm_beat_t ch_beat  [MAX_TERMS+1];

  logic      o_v_r, o_v_nxt;
  cpm_beat_t o_beat_r;
  logic      o_ready;

  assign cfg_ready = 1'b1;

  cpm_cfg #(.MAX_TERMS(MAX_TERMS)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  // Horner starts from w = 0 so the top cell just loads its coefficient
  always_comb begin
    ch_beat[0].w_re   = '0;
    ch_beat[0].w_im   = '0;
    ch_beat[0].z_re   = in_tdata[31:0];
    ch_beat[0].z_im   = in_tdata[63:32];
    ch_beat[0].cnt    = in_tdata[79:64];
    ch_beat[0].pix_ok = !in_tdata[79];
    ch_beat[0].sat    = 1'b0;
  end
  assign ch_valid[0] = in_tvalid;
  assign in_tready   = ch_ready[0];

  // cell i applies coefficient MAX_TERMS-1-i
  for (genvar i = 0; i < MAX_TERMS; i++) begin : g_cell
    cpm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .coef     (coef[MAX_TERMS-1-i]),
      .up_valid (ch_valid[i]),
      .up_ready (ch_ready[i]),
      .up_beat  (ch_beat[i]),
      .dn_valid (ch_valid[i+1]),
      .dn_ready (ch_ready[i+1]),
      .dn_beat  (ch_beat[i+1])
    );
  end

  assign o_ready             = !o_v_r || out_tready;
  assign ch_ready[MAX_TERMS] = o_ready;
  assign o_v_nxt             = o_ready ? ch_valid[MAX_TERMS] : o_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else begin
      o_v_r <= o_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready && ch_valid[MAX_TERMS]) begin
      o_beat_r <= ch_beat[MAX_TERMS];
    end
  end

  // invalid pixels carry the marker in every numeric field
  always_comb begin
    if (o_beat_r.pix_ok) begin
      out_tdata = {o_beat_r.cnt, o_beat_r.w_im, o_beat_r.w_re};
      out_tuser = {o_beat_r.sat, 1'b1};
    end else begin
      out_tdata = {INVALID_MARK16, INVALID_MARK32, INVALID_MARK32};
      out_tuser = 2'b00;
    end
  end
  assign out_tvalid = o_v_r;

`ifndef ASSERT_OFF
  invalid_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[79:64] == INVALID_MARK16 &&
      out_tdata[31:0] == INVALID_MARK32)
    else $error("invalid pixel without marker");

  invalid_not_clipped: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> !out_tuser[1])
    else $error("invalid pixel flagged saturated");

  valid_count_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> !out_tdata[79])
    else $error("transformed pixel carries a negative count");
`endif

endmodule

@@ sim/complex_polynomial_pixel_map_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// complex_polynomial_pixel_map_tb: self-checking bench for the pixel map
// Drives a directed table, then random coefficient sets and pixels, with
// random idle bursts on both streams. Every result beat is checked field by
// field against a table value or an exact Q16.16 in-bench Horner evaluator.
// ----------------------------------------------------------------------------
module complex_polynomial_pixel_map_tb;
  import cpm_pkg::*;

  localparam int MAX_TERMS    = MAX_TERMS_DEF;
  localparam int DIR_ROWS     = 34;
  localparam int RAND_PHASES  = 10;
  localparam int PHASE_ITEMS  = 125;
  localparam int DRAIN_CYCLES = 2 * MAX_TERMS + 6;
  localparam int RUN_LIMIT_NS = 5_000_000;

  localparam logic [CFG_IDX_W-1:0] REG_PAIR_1    = REG_COEF_PAIR_0 + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_2    = REG_COEF_PAIR_0 + 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_3    = REG_COEF_PAIR_0 + 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_4    = REG_COEF_PAIR_0 + 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_NONE      = 3'd0;

  localparam logic signed [31:0] PMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] PMIN = 32'sh8000_0000;

  localparam logic signed [79:0] ACC_MAX    = 80'sd2147483647;
  localparam logic signed [79:0] ACC_MIN    = -80'sd2147483648;
  localparam logic signed [79:0] ROUND_HALF = 80'sd32768;

  typedef struct packed {
    logic signed [31:0] value_re;
    logic signed [31:0] value_im;
    logic signed [15:0] count_out;
    logic               pixel_valid;
    logic               saturated;
  } pixel_result_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_PIXEL, ROW_PIXEL_TYPED} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [63:0]            data;
    logic signed [31:0]     re;
    logic signed [31:0]     im;
    logic signed [15:0]     cnt;
    pixel_result_t          want;
  } dir_row_t;

  localparam pixel_result_t NO_RESULT = '0;
  localparam pixel_result_t INVALID_RESULT =
    '{INVALID_MARK32, INVALID_MARK32, INVALID_MARK16, 1'b0, 1'b0};

  // coefficient words are {c1 im, c1 re, c0 im, c0 re}, Q4.12 each
  dir_row_t dir_table [DIR_ROWS] = '{
    // reset setting: constant zero polynomial
    '{ROW_PIXEL_TYPED, REG_NONE, 64'h0, 32'sh0, 32'sh0, 16'sd0,
      '{32'sd0, 32'sd0, 16'sd0, 1'b1, 1'b0}},
    '{ROW_PIXEL_TYPED, REG_NONE, 64'h0, PMAX, PMIN, 16'sd32767,
      '{32'sd0, 32'sd0, 16'sd32767, 1'b1, 1'b0}},
    '{ROW_PIXEL_TYPED, REG_NONE, 64'h0, PMIN, PMAX, -16'sd1, INVALID_RESULT},
    '{ROW_PIXEL_TYPED, REG_NONE, 64'h0, 32'sh1234_5678, 32'shEDCB_A988, -16'sd32768,
      INVALID_RESULT},
    // linear polynomial with extreme coefficients
    '{ROW_WRITE, REG_COEF_PAIR_0, 64'h7FFF_8000_8000_7FFF, '0, '0, '0, NO_RESULT},
    '{ROW_WRITE, REG_TERM_COUNT, 64'd2, '0, '0, '0, NO_RESULT},
    '{ROW_PIXEL, REG_NONE, 64'h0, 32'sh0001_0000, 32'sh0, 16'sd5, NO_RESULT},
    '{ROW_PIXEL, REG_NONE, 64'h0, PMAX, PMAX, 16'sd1, NO_RESULT},
    '{ROW_PIXEL, REG_NONE, 64'h0, PMIN, PMIN, 16'sd2, NO_RESULT},
    '{ROW_PIXEL, REG_NONE, 64'h0, PMIN, PMAX, 16'sd3, NO_RESULT},
    '{ROW_PIXEL, REG_NONE, 64'h0, 32'shFFFF_FFFF, 32'sh1, 16'sd4, NO_RESULT},
    '{ROW_PIXEL_TYPED, REG_NONE, 64'h0, 32'sh0001_0000, 32'sh0, -16'sd1000,
      INVALID_RESULT},
    // zero term count acts as one: constant coefficient alone
    '{ROW_WRITE, REG_TERM_COUNT, 64'd0, '0, '0, '0, NO_RESULT},
    '{ROW_PIXEL_TYPED, REG_NONE, 64'h0, 32'sh0003_0000, 32'sh2, 16'sd7,
      '{32'sd524272, -32'sd524288, 16'sd7, 1'b1, 1'b0}},
    // one LSB coefficient against half-LSB products: rounding ties
    '{ROW_WRITE, REG_COEF_PAIR_0, 64'h0000_0001_0000_0000, '0, '0, '0, NO_RESULT},
    '{ROW_WRITE, REG_TERM_COUNT, 64'd2, '0, '0, '0, NO_RESULT},
    '{ROW_PIXEL, REG_NONE, 64'h0, 32'sh0000_0800, 32'sh0, 16'sd8, NO_RESULT},
    '{ROW_PIXEL, REG_NONE, 64'h0, 32'shFFFF_F800, 32'sh0, 16'sd9, NO_RESULT},
    '{ROW_PIXEL, REG_NONE, 64'h0, 32'sh0000_0800, 32'sh0000_0800, 16'sd10, NO_RESULT},
    // full-length polynomials; term counts above the maximum clamp
    '{ROW_WRITE, REG_PAIR_1, 64'h7FFF_7FFF_7FFF_7FFF, '0, '0, '0, NO_RESULT},
    '{ROW_WRITE, REG_PAIR_2, 64'h8000_8000_8000_8000, '0, '0, '0, NO_RESULT},
    '{ROW_WRITE, REG_PAIR_3, 64'h7FFF_8000_7FFF_8000, '0, '0, '0, NO_RESULT},
    '{ROW_WRITE, REG_PAIR_4, 64'h8000_7FFF_8000_7FFF, '0, '0, '0, NO_RESULT},
    '{ROW_WRITE, REG_TERM_COUNT, 64'd15, '0, '0, '0, NO_RESULT},
    '{ROW_PIXEL, REG_NONE, 64'h0, 32'sh0000_C000, 32'shFFFF_4000, 16'sd11, NO_RESULT},
    '{ROW_PIXEL, REG_NONE, 64'h0, PMAX, PMIN, 16'sd12, NO_RESULT},
    '{ROW_PIXEL, REG_NONE, 64'h0, 32'sh0001_0000, 32'sh0001_0000, 16'sd13, NO_RESULT},
    '{ROW_WRITE, REG_TERM_COUNT, 64'd11, '0, '0, '0, NO_RESULT},
    '{ROW_PIXEL, REG_NONE, 64'h0, 32'sh0000_8000, 32'sh0000_8000, 16'sd14, NO_RESULT},
    '{ROW_WRITE, REG_TERM_COUNT, 64'd10, '0, '0, '0, NO_RESULT},
    '{ROW_PIXEL, REG_NONE, 64'h0, 32'sh0, 32'sh0, 16'sd15, NO_RESULT},
    // writes to spare indexes must leave the setting alone
    '{ROW_WRITE, REG_UNUSED_LO, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0, '0, NO_RESULT},
    '{ROW_WRITE, REG_UNUSED_HI, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0, '0, NO_RESULT},
    '{ROW_PIXEL, REG_NONE, 64'h0, 32'sh0001_0000, 32'sh0, 16'sd16, NO_RESULT}
  };

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [63:0]          cfg_data   = '0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [79:0]          in_tdata   = '0;  // point_re, point_im, inversion_count
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [79:0]          out_tdata;        // value_re, value_im, count_out
  logic [1:0]           out_tuser;        // pixel_valid, saturated

  // coefficient and term count shadow, at reset values
  logic [63:0]   coef_pairs [PAIR_REGS] = '{default: 64'h0};
  logic [3:0]    term_count_reg = 4'd1;

  pixel_result_t pending_values [$];
  pixel_result_t head_value;
  int            error_count = 0;
  int            ready_left  = 0;
  bit            quiet_mode  = 1'b0;

  complex_polynomial_pixel_map #(.MAX_TERMS(MAX_TERMS)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // coefficient k as Q16.16; slots past the stored ten read as zero
  function automatic logic signed [79:0] coef_q16(int k, int part);
    logic [63:0]        word;
    logic signed [15:0] c;
    logic signed [79:0] wide;
    if (k >= COEF_SLOTS) return '0;
    word = coef_pairs[k / 2];
    c    = word[(k % 2) * 32 + part * 16 +: 16];
    wide = 80'(c);
    return wide <<< 4;
  endfunction

  function automatic logic signed [79:0] clip_q16(logic signed [79:0] v);
    if (v > ACC_MAX) return ACC_MAX;
    if (v < ACC_MIN) return ACC_MIN;
    return v;
  endfunction

  function automatic pixel_result_t eval_polynomial(logic signed [31:0] re,
                                                    logic signed [31:0] im,
                                                    logic signed [15:0] cnt);
    pixel_result_t      res;
    logic signed [79:0] zr, zi, wr, wi, nr, ni;
    logic               clipped;
    int                 n, k;
    if (cnt < 0) return INVALID_RESULT;
    zr = 80'(re);
    zi = 80'(im);
    n  = int'(term_count_reg);
    if (n < 1) n = 1;
    if (n > MAX_TERMS) n = MAX_TERMS;
    wr      = coef_q16(n - 1, 0);
    wi      = coef_q16(n - 1, 1);
    clipped = 1'b0;
    for (k = n - 2; k >= 0; k--) begin
      // exact Q32.32 product, round half up to Q16.16, add coefficient
      nr = ((wr * zr - wi * zi + ROUND_HALF) >>> 16) + coef_q16(k, 0);
      ni = ((wr * zi + wi * zr + ROUND_HALF) >>> 16) + coef_q16(k, 1);
      clipped |= (nr != clip_q16(nr)) || (ni != clip_q16(ni));
      wr = clip_q16(nr);
      wi = clip_q16(ni);
    end
    res.value_re    = wr[31:0];
    res.value_im    = wi[31:0];
    res.count_out   = cnt;
    res.pixel_valid = 1'b1;
    res.saturated   = clipped;
    return res;
  endfunction

  function automatic logic [63:0] random_pair();
    logic [63:0] word;
    int          mode;
    mode = $urandom_range(0, 2);
    word = {$urandom, $urandom};
    for (int p = 0; p < 4; p++) begin
      if (mode == 1) begin
        word[p * 16 +: 16] = 16'($urandom_range(0, 1023)) - 16'd512;
      end else if (mode == 2) begin
        case ($urandom_range(0, 3))
          0: word[p * 16 +: 16] = 16'h7FFF;
          1: word[p * 16 +: 16] = 16'h8000;
          2: word[p * 16 +: 16] = 16'h0000;
          default: word[p * 16 +: 16] = 16'h1000;
        endcase
      end
    end
    return word;
  endfunction

  // mostly moderate magnitudes so long polynomials do not always clip
  function automatic logic signed [31:0] random_point();
    logic signed [31:0] v;
    int                 sel;
    sel = $urandom_range(0, 9);
    v   = $urandom;
    if (sel == 0) return PMAX;
    if (sel == 1) return PMIN;
    if (sel < 4) return v;
    return v >>> (32 - $urandom_range(4, 20));
  endfunction

  function automatic logic signed [15:0] random_count();
    logic signed [15:0] c;
    c = 16'($urandom);
    case ($urandom_range(0, 15))
      0: c = 16'sd0;
      1: c = 16'sd32767;
      2: c = -16'sd32768;
      3, 4: ;
      default: c[15] = 1'b0;
    endcase
    return c;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    in_tvalid <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx < PAIR_REGS) coef_pairs[idx] = data;
    else if (idx == REG_TERM_COUNT) term_count_reg = data[3:0];
  endtask

  task automatic send_pixel(logic signed [31:0] re, logic signed [31:0] im,
                            logic signed [15:0] cnt, bit typed, pixel_result_t want);
    if (!quiet_mode && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {cnt, im, re};
    do @(posedge clk); while (!in_tready);
    pending_values.push_back(typed ? want : eval_polynomial(re, im, cnt));
  endtask

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // result side: ready and stall bursts, none in the quiet phase
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      ready_left <= 0;
    end else if (ready_left != 0) begin
      ready_left <= ready_left - 1;
    end else if (quiet_mode || $urandom_range(0, 2) != 0) begin
      out_tready <= 1'b1;
      ready_left <= $urandom_range(0, 11);
    end else begin
      out_tready <= 1'b0;
      ready_left <= $urandom_range(0, 4);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_values.size() == 0) begin
        $error("result beat with no pending value: tdata %h tuser %b", out_tdata, out_tuser);
        error_count++;
      end else begin
        head_value = pending_values.pop_front();
        check_field("value_re", longint'(head_value.value_re),
                    longint'($signed(out_tdata[31:0])));
        check_field("value_im", longint'(head_value.value_im),
                    longint'($signed(out_tdata[63:32])));
        check_field("count_out", longint'(head_value.count_out),
                    longint'($signed(out_tdata[79:64])));
        check_field("pixel_valid", longint'(head_value.pixel_valid),
                    longint'(out_tuser[0]));
        check_field("saturated", longint'(head_value.saturated),
                    longint'(out_tuser[1]));
      end
    end
  end

  initial begin
    logic [63:0] tc_word;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_table[i].kind == ROW_WRITE)
        write_reg(dir_table[i].idx, dir_table[i].data);
      else
        send_pixel(dir_table[i].re, dir_table[i].im, dir_table[i].cnt,
                   dir_table[i].kind == ROW_PIXEL_TYPED, dir_table[i].want);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      quiet_mode = (ph == RAND_PHASES - 1);
      for (int r = 0; r < PAIR_REGS; r++)
        write_reg(REG_COEF_PAIR_0 + 3'(r), random_pair());
      // upper bits of the term count word are don't-care
      tc_word = {$urandom, $urandom};
      case (ph)
        0: tc_word[3:0] = 4'(MAX_TERMS);
        1: tc_word[3:0] = 4'd15;
        2: tc_word[3:0] = 4'd0;
        3: tc_word[3:0] = 4'd1;
        default: ;
      endcase
      write_reg(REG_TERM_COUNT, tc_word);
      if ($urandom_range(0, 2) == 0)
        write_reg($urandom_range(0, 1) ? REG_UNUSED_HI : REG_UNUSED_LO, {$urandom, $urandom});
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_pixel(random_point(), random_point(), random_count(), 1'b0, NO_RESULT);
    end

    in_tvalid <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ complex_polynomial_pixel_map.f @@
sv/cpm_pkg.sv
sv/cpm_cfg.sv
sv/cpm_cell.sv
sv/complex_polynomial_pixel_map.sv
sim/complex_polynomial_pixel_map_tb.sv
